>>> sv/lstc_pkg.sv
// Shared types and constants for the LED sequencer and tone controller.
// No dependencies; every RTL file in this block imports it.
`default_nettype none

package lstc_pkg;

   // widths of the fields and registers
   localparam int unsigned INTERVAL_W = 10;
   localparam int unsigned DELAY_W    = 6;
   localparam int unsigned LED_W      = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 10;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_LED_INTERVAL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_INTERVAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TONE_DELAY = 2'd2;

   // register values after reset
   localparam logic [INTERVAL_W-1:0] LED_INTERVAL_RST   = 10'd300;
   localparam logic [INTERVAL_W-1:0] BLINK_INTERVAL_RST = 10'd1000;
   localparam logic [DELAY_W-1:0]    MAX_TONE_DELAY_RST = 6'd50;

   // rotator phase codes: dark before the first step, then one LED each
   localparam logic [1:0] ROT_DARK  = 2'd0;
   localparam logic [1:0] ROT_LAST  = 2'd3;
   localparam logic [1:0] ROT_FIRST = 2'd1;
   localparam logic [1:0] ROT_MID   = 2'd2;

   // blink phase codes
   localparam logic [1:0] BLINK_DARK = 2'd0;
   localparam logic [1:0] BLINK_LIT  = 2'd1;
   localparam logic [1:0] BLINK_OFF  = 2'd2;

   typedef enum logic [1:0] {
      TONE_INIT = 2'd0,
      TONE_WAIT = 2'd1,
      TONE_ON   = 2'd2,
      TONE_OFF  = 2'd3
   } tone_phase_type;

   typedef enum logic [2:0] {
      ADJ_START    = 3'd0,
      ADJ_INC      = 3'd1,
      ADJ_DEC      = 3'd2,
      ADJ_INC_HOLD = 3'd3,
      ADJ_DEC_HOLD = 3'd4
   } adjust_phase_type;

   typedef struct packed {
      logic button_toggle;
      logic button_up;
      logic button_down;
   } req_word_type;

   typedef struct packed {
      logic [LED_W-1:0]   led_pattern;
      logic               blink_on;
      logic               tone_on;
      logic [DELAY_W-1:0] tone_delay_now;
   } rsp_word_type;

endpackage

`default_nettype wire

>>> sv/lstc_delay_adj.sv
// Up/down button machine and the adjustable tone delay register.
// Depends on lstc_pkg for the adjust phase type and widths.
`default_nettype none

module lstc_delay_adj
   import lstc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               button_up,
   input  wire logic               button_down,
   input  wire logic [DELAY_W-1:0] max_delay,
   output logic      [DELAY_W-1:0] delay_next
);

   adjust_phase_type   adjust_ff, adjust_in;
   logic [DELAY_W-1:0] delay_ff;
   logic               none_held, only_up, only_down;

   assign none_held = !button_up && !button_down;
   assign only_up   = button_up && !button_down;
   assign only_down = button_down && !button_up;

   always_comb begin
      case (adjust_ff)
         ADJ_INC: begin
            adjust_in = only_up ? ADJ_INC_HOLD : ADJ_START;
         end
         ADJ_DEC: begin
            adjust_in = only_down ? ADJ_DEC_HOLD : ADJ_START;
         end
         ADJ_INC_HOLD: begin
            adjust_in = none_held ? ADJ_START : ADJ_INC_HOLD;
         end
         ADJ_DEC_HOLD: begin
            adjust_in = none_held ? ADJ_START : ADJ_DEC_HOLD;
         end
         default: begin
            if (only_up) begin
               adjust_in = ADJ_INC;
            end else if (only_down) begin
               adjust_in = ADJ_DEC;
            end else begin
               adjust_in = ADJ_START;
            end
         end
      endcase
   end

   // step the delay on entry to inc/dec; a lowered clamp does not cut it
   always_comb begin
      delay_next = delay_ff;
      if (adjust_in == ADJ_INC && delay_ff < max_delay) begin
         delay_next = DELAY_W'(delay_ff + 1'b1);
      end else if (adjust_in == ADJ_DEC && delay_ff != '0) begin
         delay_next = DELAY_W'(delay_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adjust_ff <= ADJ_START;
         delay_ff  <= '0;
      end else if (accept) begin
         adjust_ff <= adjust_in;
         delay_ff  <= delay_next;
      end
   end

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(accept)) |-> ($stable(delay_ff) && $stable(adjust_ff)))
      else $error("delay state moved without a word");

   a_step_one: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(accept)) |->
         (delay_ff == $past(delay_ff) || delay_ff == DELAY_W'($past(delay_ff) + 1'b1)
          || delay_ff == DELAY_W'($past(delay_ff) - 1'b1)))
      else $error("delay moved by more than one");

   a_inc_clamped: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(accept) && delay_ff == DELAY_W'($past(delay_ff) + 1'b1))
         |-> ($past(delay_ff) < $past(max_delay) && adjust_ff == ADJ_INC))
      else $error("delay raised past the clamp or outside increment");

endmodule

`default_nettype wire

>>> sv/led_sequencer_tone_controller.sv
// LED sequencer and tone controller: one req word is one timer tick with three
// active-high buttons and yields exactly one rsp word (LED rotator, blinker,
// speaker bit, current tone delay). A word is taken every cycle unless req_stall
// is high; all state updates in the cycle of acceptance and the result sits in
// an output register backed by a one-word skid stage, and one more word is
// taken while a result waits before req_stall rises. Write csr registers only
// while idle.
`default_nettype none

module led_sequencer_tone_controller
   import lstc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_word_type          req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_word_type               rsp_word,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [INTERVAL_W-1:0] led_interval_ff, blink_interval_ff;
   logic [DELAY_W-1:0]    max_delay_ff;

   logic [1:0]            rot_phase_ff, rot_phase_in;
   logic [1:0]            blink_phase_ff, blink_phase_in;
   logic [INTERVAL_W-1:0] rot_count_ff, rot_count_in;
   logic [INTERVAL_W-1:0] blink_count_ff, blink_count_in;
   tone_phase_type        tone_phase_ff, tone_phase_in;
   logic [DELAY_W-1:0]    tone_count_ff, tone_count_in;
   logic [DELAY_W-1:0]    delay_next;

   rsp_word_type          result;
   rsp_word_type          out_ff, skid_ff;
   logic                  out_vld_ff, skid_vld_ff;
   logic                  accept, out_take;

   assign req_stall = skid_vld_ff;
   assign accept    = req_valid && !req_stall;
   assign out_take  = out_vld_ff && !rsp_stall;
   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_interval_ff   <= LED_INTERVAL_RST;
         blink_interval_ff <= BLINK_INTERVAL_RST;
         max_delay_ff      <= MAX_TONE_DELAY_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LED_INTERVAL:   led_interval_ff   <= csr_wdata;
            CSR_BLINK_INTERVAL: blink_interval_ff <= csr_wdata;
            CSR_MAX_TONE_DELAY: max_delay_ff      <= csr_wdata[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   lstc_delay_adj u_delay_adj (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .button_up  (req_word.button_up),
      .button_down(req_word.button_down),
      .max_delay  (max_delay_ff),
      .delay_next (delay_next)
   );

   always_comb begin
      // rotator: step and clear once the count reaches the interval
      rot_phase_in = rot_phase_ff;
      if (rot_count_ff >= led_interval_ff) begin
         rot_phase_in = (rot_phase_ff == ROT_LAST) ? ROT_FIRST : 2'(rot_phase_ff + 1'b1);
         rot_count_in = '0;
      end else begin
         rot_count_in = INTERVAL_W'(rot_count_ff + 1'b1);
      end

      blink_phase_in = blink_phase_ff;
      if (blink_count_ff >= blink_interval_ff) begin
         blink_phase_in = (blink_phase_ff == BLINK_LIT) ? BLINK_OFF : BLINK_LIT;
         blink_count_in = '0;
      end else begin
         blink_count_in = INTERVAL_W'(blink_count_ff + 1'b1);
      end

      case (tone_phase_ff)
         TONE_INIT: tone_phase_in = TONE_WAIT;
         TONE_ON:   tone_phase_in = req_word.button_toggle ? TONE_OFF : TONE_WAIT;
         default:   tone_phase_in = req_word.button_toggle ? TONE_ON : TONE_WAIT;
      endcase

      result.tone_on = 1'b0;
      if (tone_count_ff >= delay_next) begin
         result.tone_on = (tone_phase_in == TONE_ON);
         tone_count_in  = '0;
      end else begin
         tone_count_in = DELAY_W'(tone_count_ff + 1'b1);
      end

      case (rot_phase_in)
         ROT_DARK:  result.led_pattern = 3'b000;
         ROT_FIRST: result.led_pattern = 3'b001;
         ROT_MID:   result.led_pattern = 3'b010;
         default:   result.led_pattern = 3'b100;
      endcase
      result.blink_on       = (blink_phase_in == BLINK_LIT);
      result.tone_delay_now = delay_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_phase_ff   <= ROT_DARK;
         blink_phase_ff <= BLINK_DARK;
         rot_count_ff   <= '0;
         blink_count_ff <= '0;
         tone_phase_ff  <= TONE_INIT;
         tone_count_ff  <= '0;
      end else if (accept) begin
         rot_phase_ff   <= rot_phase_in;
         blink_phase_ff <= blink_phase_in;
         rot_count_ff   <= rot_count_in;
         blink_count_ff <= blink_count_in;
         tone_phase_ff  <= tone_phase_in;
         tone_count_ff  <= tone_count_in;
      end
   end

   // output register with one-word skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (!out_vld_ff || out_take) begin
               out_vld_ff <= 1'b1;
            end else begin
               skid_vld_ff <= 1'b1;
            end
         end else if (out_take) begin
            out_vld_ff  <= skid_vld_ff;
            skid_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (!out_vld_ff || out_take) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end else if (out_take && skid_vld_ff) begin
         out_ff <= skid_ff;
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid word held with the output register empty");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && rsp_stall) |=> (skid_vld_ff && out_vld_ff))
      else $error("stalled word lost");

   a_led_onehot: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> $onehot0(out_ff.led_pattern))
      else $error("rotator LEDs not one-hot");

endmodule

`default_nettype wire
